/* src/sbsm_pkg.sv */
// Shared types and constants for the serial bank switch mapper.
// No dependencies; imported by sbsm_translate, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package sbsm_pkg;

  // access kinds carried in the operation field
  localparam logic [2:0] OP_PRG_READ  = 3'd0;
  localparam logic [2:0] OP_PRG_WRITE = 3'd1;
  localparam logic [2:0] OP_CHR_READ  = 3'd2;
  localparam logic [2:0] OP_CHR_WRITE = 3'd3;
  localparam logic [2:0] OP_WRAM      = 3'd4;

  // configuration register indexes
  localparam logic CFG_PRG_BANK_COUNT  = 1'b0;
  localparam logic CFG_CHR_ROM_PRESENT = 1'b1;

  // target register picked by address bits 15..13 on the fifth serial write
  localparam logic [2:0] TGT_CONTROL  = 3'b100;
  localparam logic [2:0] TGT_CHR_LOW  = 3'b101;
  localparam logic [2:0] TGT_CHR_HIGH = 3'b110;
  localparam logic [2:0] TGT_PRG      = 3'b111;

  localparam logic [4:0]  CONTROL_RESET    = 5'h1c;
  localparam logic [4:0]  PRG_COUNT_RESET  = 5'd16;
  localparam logic        CHR_ROM_RESET    = 1'b1;
  localparam logic [2:0]  LOAD_WRITES      = 3'd5;
  localparam logic [17:0] WRAM_BASE        = 18'h06000;

  // bank registers that steer address translation
  typedef struct packed {
    logic [4:0] control_word;   // 1..0 mirroring, 3..2 program mode, 4 pattern 4k mode
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [4:0] chr_bank_eight;
    logic [3:0] prg_bank_low;
    logic [3:0] prg_bank_high;
    logic [2:0] prg_bank_wide;
  } sbsm_banks_t;

endpackage

`default_nettype wire

/* src/sbsm_translate.sv */
// Address translation for one access from the current bank registers.
// Depends on sbsm_pkg for operation codes and the bank register struct.
`timescale 1ns / 1ps
`default_nettype none

module sbsm_translate import sbsm_pkg::*; (
  input  wire logic [2:0]  operation,
  input  wire logic [15:0] address,
  input  wire sbsm_banks_t banks,
  input  wire logic        chr_rom_present,
  output logic [17:0]      mapped_address
);

  logic [17:0] prg_mapped;
  logic [17:0] chr_mapped;
  logic [17:0] wram_mapped;

  // program window: 32k mode for modes 0/1, split 16k otherwise
  always_comb begin
    if (banks.control_word[3]) begin
      if (address <= 16'hbfff) begin
        prg_mapped = {banks.prg_bank_low, address[13:0]};
      end else begin
        prg_mapped = {banks.prg_bank_high, address[13:0]};
      end
    end else begin
      prg_mapped = {banks.prg_bank_wide, address[14:0]};
    end
  end

  // pattern window: pass-through for ram, two 4k banks or one 8k bank
  always_comb begin
    if (!chr_rom_present) begin
      chr_mapped = {2'b00, address};
    end else if (banks.control_word[4]) begin
      if (address <= 16'h0fff) begin
        chr_mapped = {1'b0, banks.chr_bank_low, address[11:0]};
      end else begin
        chr_mapped = {1'b0, banks.chr_bank_high, address[11:0]};
      end
    end else begin
      chr_mapped = {1'b0, banks.chr_bank_eight[4:1], address[12:0]};
    end
  end

  assign wram_mapped = {2'b00, address} - WRAM_BASE;

  // select by access kind
  always_comb begin
    unique case (operation)
      OP_PRG_READ:  mapped_address = prg_mapped;
      OP_CHR_READ:  mapped_address = chr_mapped;
      OP_CHR_WRITE: mapped_address = {2'b00, address};
      OP_WRAM:      mapped_address = wram_mapped;
      default:      mapped_address = 18'd0;
    endcase
  end

endmodule

`default_nettype wire

/* src/serial_bank_switch_mapper_unit.sv */
// Top level of the serial bank switch mapper: stream ports, state and result register.
// Depends on sbsm_pkg and sbsm_translate.
`timescale 1ns / 1ps
`default_nettype none

// One bus access per item, one item per cycle sustained while the result side
// takes results; an item passes through the input register, then the result register.
// Program writes feed a five-bit serial load; the fifth write lands in the
// register chosen by address bits 15..13, and a write with bit 7 set clears
// the load and forces program mode 3. The state update of one item is
// registered before the next item is translated, so the register feedback through
// the commit logic sets the clock. mirror_mode carries the mirroring mode
// after the item's own update. Configuration writes take effect at once, and
// a bank count write reloads the fixed upper program bank with the count minus one.
module serial_bank_switch_mapper_unit import sbsm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // operation[2:0], address[18:3], write_data[26:19]
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // mapped_address[17:0], mirror_mode[19:18]
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data
);

  // configuration registers
  logic [4:0] prg_bank_count;
  logic       chr_rom_present;
  logic [4:0] count_less_one;
  logic [3:0] last_bank;

  // input register
  logic        s1_valid;
  logic [2:0]  s1_op;
  logic [15:0] s1_addr;
  logic [7:0]  s1_data;
  logic        s1_adv;
  logic        out_free;

  // mapper state
  sbsm_banks_t banks;
  sbsm_banks_t banks_next;
  logic [4:0]  shift_load;
  logic [4:0]  shift_load_next;
  logic [2:0]  write_count;
  logic [2:0]  write_count_next;
  logic [1:0]  mirroring;
  logic [1:0]  mirroring_next;
  logic [4:0]  shifted;
  logic [2:0]  count_inc;

  logic [17:0] mapped_address;

  assign count_less_one = prg_bank_count - 5'd1;
  assign last_bank      = count_less_one[3:0];

  // handshake: result register frees when empty or taken
  assign out_free = !m_tvalid || m_tready;
  assign s1_adv   = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_op   <= s_tdata[2:0];
      s1_addr <= s_tdata[18:3];
      s1_data <= s_tdata[26:19];
    end
  end

  // address translation from the state before this item
  sbsm_translate u_translate (
    .operation       (s1_op),
    .address         (s1_addr),
    .banks           (banks),
    .chr_rom_present (chr_rom_present),
    .mapped_address  (mapped_address)
  );

  // serial load and bank register update
  assign shifted   = {s1_data[0], shift_load[4:1]};
  assign count_inc = write_count + 3'd1;

  always_comb begin
    banks_next       = banks;
    shift_load_next  = shift_load;
    write_count_next = write_count;
    mirroring_next   = mirroring;
    if (s1_adv && s1_op == OP_PRG_WRITE) begin
      if (s1_data[7]) begin
        shift_load_next  = 5'd0;
        write_count_next = 3'd0;
        banks_next.control_word = banks.control_word | 5'h0c;
      end else if (count_inc >= LOAD_WRITES) begin
        shift_load_next  = 5'd0;
        write_count_next = 3'd0;
        unique case (s1_addr[15:13])
          TGT_CONTROL: begin
            banks_next.control_word = shifted;
            mirroring_next = shifted[1:0];
          end
          TGT_CHR_LOW: begin
            if (banks.control_word[4]) begin
              banks_next.chr_bank_low = shifted;
            end else begin
              banks_next.chr_bank_eight = shifted;
            end
          end
          TGT_CHR_HIGH: begin
            if (banks.control_word[4]) begin
              banks_next.chr_bank_high = shifted;
            end
          end
          TGT_PRG: begin
            if (!banks.control_word[3]) begin
              banks_next.prg_bank_wide = shifted[3:1];
            end else if (!banks.control_word[2]) begin
              banks_next.prg_bank_high = shifted[3:0];
              banks_next.prg_bank_low  = 4'd0;
            end else begin
              banks_next.prg_bank_high = last_bank;
              banks_next.prg_bank_low  = shifted[3:0];
            end
          end
          default: begin
          end
        endcase
      end else begin
        shift_load_next  = shifted;
        write_count_next = count_inc;
      end
    end
    // bank count write reloads the fixed upper program bank
    if (cfg_we && cfg_index == CFG_PRG_BANK_COUNT) begin
      banks_next.prg_bank_high = cfg_data[3:0] - 4'd1;
    end
  end

  // state registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count  <= PRG_COUNT_RESET;
      chr_rom_present <= CHR_ROM_RESET;
      shift_load      <= 5'd0;
      write_count     <= 3'd0;
      mirroring       <= 2'd0;
      banks           <= '{control_word: CONTROL_RESET, chr_bank_low: 5'd0,
                           chr_bank_high: 5'd0, chr_bank_eight: 5'd0,
                           prg_bank_low: 4'd0, prg_bank_high: 4'hf,
                           prg_bank_wide: 3'd0};
    end else begin
      shift_load  <= shift_load_next;
      write_count <= write_count_next;
      mirroring   <= mirroring_next;
      banks       <= banks_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PRG_BANK_COUNT:  prg_bank_count  <= cfg_data;
          CFG_CHR_ROM_PRESENT: chr_rom_present <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= {4'd0, mirroring_next,
                  (s1_op == OP_PRG_WRITE) ? 18'd0 : mapped_address};
    end
  end

`ifndef ASSERT_OFF
  // the serial load never holds five bits without committing
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    write_count < LOAD_WRITES)
    else $error("serial write count out of range");

  // a program write with the reset bit forces program mode 3
  a_reset_bit: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_op == OP_PRG_WRITE && s1_data[7] && !cfg_we
    |=> banks.control_word[3:2] == 2'b11 && write_count == 3'd0)
    else $error("reset bit did not force program mode 3");

  // an item taken reaches the input register
  a_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> s1_valid)
    else $error("accepted item lost before processing");

  // a program write result carries a zero address
  a_prg_write_zero: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_op == OP_PRG_WRITE |=> m_tdata[17:0] == 18'd0)
    else $error("program write gave a nonzero address");
`endif

endmodule

`default_nettype wire

/* sim/serial_bank_switch_mapper_unit_test.sv */
// Self-checking testbench for serial_bank_switch_mapper_unit: bus accesses, serial register
// loads and configuration settings are checked against a bank-state predictor kept here.
// Depends on sbsm_pkg and the mapper RTL only.
`timescale 1ns / 1ps

module serial_bank_switch_mapper_unit_test;
  import sbsm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int HOLD_OFF_LEN   = 300;

  // access kinds the block treats as no-ops
  localparam logic [2:0] OP_UNUSED_LOW  = 3'd5;
  localparam logic [2:0] OP_UNUSED_HIGH = 3'd7;

  // program modes held in control bits 3..2
  localparam logic [1:0] PRG_MODE_SWAP_HIGH = 2'd2;
  localparam logic [4:0] PRG_MODE_BITS      = 5'h0c;

  typedef struct packed {
    logic [17:0] mapped;
    logic [1:0]  mirror;
  } map_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // operation[2:0], address[18:3], write_data[26:19]
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [23:0] m_tdata;         // mapped_address[17:0], mirror_mode[19:18]
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [4:0]  cfg_data = '0;

  serial_bank_switch_mapper_unit uut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data
  );

  // predicted mapper state
  sbsm_banks_t banks;
  logic [4:0]  serial_load;
  logic [2:0]  serial_count;
  logic [1:0]  mirror_now;
  logic [4:0]  bank_count;
  logic        chr_rom;

  map_result_t pending_maps[$];
  map_result_t oldest_map;

  int items_sent;
  int results_checked;
  int fail_count;
  int loads_done;
  int settings_done;
  int send_gap_pct;
  int recv_stall_pct;
  int hold_cycles;
  int stall_left;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [3:0] last_prg_bank();
    logic [4:0] top;
    top = bank_count - 5'd1;
    return top[3:0];
  endfunction

  function automatic void reset_predictor();
    bank_count           = PRG_COUNT_RESET;
    chr_rom              = CHR_ROM_RESET;
    serial_load          = '0;
    serial_count         = '0;
    banks                = '0;
    banks.control_word   = CONTROL_RESET;
    banks.prg_bank_high  = last_prg_bank();
    mirror_now           = '0;
  endfunction

  // fifth serial write: address bits 15..13 pick the register
  function automatic void commit_load(input logic [15:0] addr);
    case (addr[15:13])
      TGT_CONTROL: begin
        banks.control_word = serial_load;
        mirror_now = serial_load[1:0];
      end
      TGT_CHR_LOW: begin
        if (banks.control_word[4]) banks.chr_bank_low = serial_load;
        else banks.chr_bank_eight = serial_load;
      end
      TGT_CHR_HIGH: begin
        if (banks.control_word[4]) banks.chr_bank_high = serial_load;
      end
      TGT_PRG: begin
        if (banks.control_word[3:2] < PRG_MODE_SWAP_HIGH) begin
          banks.prg_bank_wide = serial_load[3:1];
        end else if (banks.control_word[3:2] == PRG_MODE_SWAP_HIGH) begin
          banks.prg_bank_high = serial_load[3:0];
          banks.prg_bank_low  = '0;
        end else begin
          banks.prg_bank_high = last_prg_bank();
          banks.prg_bank_low  = serial_load[3:0];
        end
      end
      default: ;
    endcase
    if (addr[15]) loads_done++;
    serial_load  = '0;
    serial_count = '0;
  endfunction

  // applies one access to the predicted state and returns its result
  function automatic map_result_t map_access(input logic [2:0] op, input logic [15:0] addr,
                                             input logic [7:0] data);
    map_result_t r;
    logic [3:0]  prg_bank;
    logic [4:0]  chr_bank;
    r.mapped = '0;
    case (op)
      OP_PRG_READ: begin
        if (banks.control_word[3:2] >= PRG_MODE_SWAP_HIGH) begin
          prg_bank = (addr <= 16'hbfff) ? banks.prg_bank_low : banks.prg_bank_high;
          r.mapped = {prg_bank, addr[13:0]};
        end else begin
          r.mapped = {banks.prg_bank_wide, addr[14:0]};
        end
      end
      OP_PRG_WRITE: begin
        if (data[7]) begin
          serial_load  = '0;
          serial_count = '0;
          banks.control_word = banks.control_word | PRG_MODE_BITS;
        end else begin
          serial_load  = {data[0], serial_load[4:1]};
          serial_count = serial_count + 3'd1;
          if (serial_count >= LOAD_WRITES) commit_load(addr);
        end
      end
      OP_CHR_READ: begin
        if (!chr_rom) begin
          r.mapped = {2'b00, addr};
        end else if (banks.control_word[4]) begin
          chr_bank = (addr <= 16'h0fff) ? banks.chr_bank_low : banks.chr_bank_high;
          r.mapped = {1'b0, chr_bank, addr[11:0]};
        end else begin
          r.mapped = {1'b0, banks.chr_bank_eight[4:1], addr[12:0]};
        end
      end
      OP_CHR_WRITE: r.mapped = {2'b00, addr};
      OP_WRAM:      r.mapped = {2'b00, addr} - WRAM_BASE;
      default: ;
    endcase
    r.mirror = mirror_now;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct) stall_left = pick_gap();
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (pending_maps.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: mapped %h mirror %0d", m_tdata[17:0], m_tdata[19:18]);
      end else begin
        oldest_map = pending_maps.pop_front();
        results_checked++;
        if (m_tdata[17:0] !== oldest_map.mapped || m_tdata[19:18] !== oldest_map.mirror) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result %0d: expected mapped %h mirror %0d, got mapped %h mirror %0d",
                     results_checked, oldest_map.mapped, oldest_map.mirror,
                     m_tdata[17:0], m_tdata[19:18]);
        end
      end
    end
  end

  // stop the run if nothing moves on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // offer one item, predict it once taken, maybe leave a gap
  task automatic send_access(input logic [2:0] op, input logic [15:0] addr,
                             input logic [7:0] data);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, data, addr, op};
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_maps.push_back(map_access(op, addr, data));
    items_sent++;
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      gap = pick_gap();
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(input logic idx, input logic [4:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PRG_BANK_COUNT) begin
      bank_count = value;
      banks.prg_bank_high = last_prg_bank();
    end else begin
      chr_rom = value[0];
    end
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [4:0] count, input logic rom);
    wait_results_drained();
    write_setting(CFG_PRG_BANK_COUNT, count);
    write_setting(CFG_CHR_ROM_PRESENT, {4'd0, rom});
    settings_done++;
  endtask

  // program read, pattern read or write, or work ram access, address mostly biased toward its window
  task automatic send_read();
    logic [15:0] addr;
    logic [2:0]  op;
    addr = 16'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        op = OP_PRG_READ;
        if ($urandom_range(0, 4) != 0) addr[15] = 1'b1;
      end
      1: begin
        op = OP_CHR_READ;
        if ($urandom_range(0, 4) != 0) addr[15:13] = 3'b000;
      end
      2: op = OP_CHR_WRITE;
      default: begin
        op = OP_WRAM;
        if ($urandom_range(0, 4) != 0) addr[15:13] = 3'b011;
      end
    endcase
    send_access(op, addr, 8'($urandom));
  endtask

  function automatic logic [7:0] serial_byte(input logic b);
    logic [7:0] d;
    d = 8'($urandom);
    d[7] = 1'b0;
    d[0] = b;
    return d;
  endfunction

  // five serial writes, the last to the target (or below the register window if asked), other accesses mixed in
  task automatic load_register(input logic [2:0] tgt, input logic [4:0] value,
                               input logic below_window);
    logic [15:0] addr;
    for (int i = 0; i < 5; i++) begin
      addr = 16'($urandom);
      if (i == 4) begin
        if (below_window) addr[15] = 1'b0;
        else addr[15:13] = tgt;
      end
      send_access(OP_PRG_WRITE, addr, serial_byte(value[i]));
      if ($urandom_range(0, 99) < 15) send_read();
    end
  endtask

  task automatic send_reset_bit();
    send_access(OP_PRG_WRITE, 16'($urandom), 8'h80 | 8'($urandom));
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    int r;
    logic [2:0] tgt;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        case ($urandom_range(0, 3))
          0: tgt = TGT_CONTROL;
          1: tgt = TGT_CHR_LOW;
          2: tgt = TGT_CHR_HIGH;
          default: tgt = TGT_PRG;
        endcase
        load_register(tgt, 5'($urandom), $urandom_range(0, 9) == 0);
      end else if (r < 80) begin
        send_read();
      end else if (r < 88) begin
        // broken load: a few bits, then the reset bit
        repeat ($urandom_range(1, 4))
          send_access(OP_PRG_WRITE, 16'($urandom), serial_byte(1'($urandom)));
        send_reset_bit();
      end else if (r < 92) begin
        send_reset_bit();
      end else begin
        send_access(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  // extremes after reset, no-op kinds, reset bit, one control load
  task automatic test_directed_accesses();
    send_access(OP_PRG_READ, 16'h8000, 8'h00);
    send_access(OP_PRG_READ, 16'hbfff, 8'hff);
    send_access(OP_PRG_READ, 16'hc000, 8'h00);
    send_access(OP_PRG_READ, 16'hffff, 8'hff);
    send_access(OP_CHR_READ, 16'h0000, 8'h00);
    send_access(OP_CHR_READ, 16'h1fff, 8'h00);
    send_access(OP_CHR_READ, 16'hffff, 8'hff);
    send_access(OP_CHR_WRITE, 16'hffff, 8'hff);
    send_access(OP_WRAM, 16'h6000, 8'h00);
    send_access(OP_WRAM, 16'h0000, 8'h00);
    send_access(OP_WRAM, 16'hffff, 8'hff);
    send_access(OP_UNUSED_LOW, 16'hffff, 8'hff);
    send_access(OP_UNUSED_HIGH, 16'h8000, 8'h01);
    // partial load cleared by the reset bit
    send_access(OP_PRG_WRITE, 16'h8000, 8'h01);
    send_access(OP_PRG_WRITE, 16'h0000, 8'h7f);
    send_access(OP_PRG_WRITE, 16'hffff, 8'hff);
    // 4k pattern banks, upper program bank fixed, horizontal mirroring
    load_register(TGT_CONTROL, 5'h1f, 1'b0);
    send_access(OP_PRG_READ, 16'h8000, 8'h00);
    send_access(OP_PRG_READ, 16'hffff, 8'h00);
    send_access(OP_CHR_READ, 16'h0fff, 8'h00);
    send_access(OP_CHR_READ, 16'h1000, 8'h00);
  endtask

  // bank count and pattern memory settings, extremes first
  task automatic test_config_settings();
    logic [4:0] counts [4] = '{5'd1, 5'd16, 5'd0, 5'd31};
    send_gap_pct   = 8;
    recv_stall_pct = 8;
    for (int i = 0; i < 6; i++) begin
      if (i < 4) apply_setting(counts[i], i[0]);
      else apply_setting(5'($urandom_range(1, 16)), 1'($urandom_range(0, 1)));
      random_traffic(110);
    end
    apply_setting(PRG_COUNT_RESET, CHR_ROM_RESET);
  endtask

  task automatic test_mixed_idling();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 25; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 30; end
        default: begin send_gap_pct = 12; recv_stall_pct = 12; end
      endcase
      random_traffic(250);
    end
  endtask

  // result side held off while input keeps coming, so the block backs up
  task automatic test_output_backpressure();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_cycles    = HOLD_OFF_LEN;
    random_traffic(60);
    wait_results_drained();
  endtask

  // input pauses until every result is out, then resumes
  task automatic test_drain_pause();
    send_gap_pct   = 10;
    recv_stall_pct = 10;
    repeat (3) begin
      random_traffic(40);
      wait_results_drained();
    end
    random_traffic(150);
  endtask

  initial begin
    reset_predictor();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_accesses();
    test_config_settings();
    test_mixed_idling();
    test_output_backpressure();
    test_drain_pause();
    wait_results_drained();
    repeat (8) @(posedge clk);
    $display("%0d accesses, %0d results checked, %0d register loads, %0d settings",
             items_sent, results_checked, loads_done, settings_done);
    $display("included a %0d-cycle result hold-off and input pauses until drained",
             HOLD_OFF_LEN);
    if (fail_count == 0 && pending_maps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, pending_maps.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/sbsm_pkg.sv
src/sbsm_translate.sv
src/serial_bank_switch_mapper_unit.sv
sim/serial_bank_switch_mapper_unit_test.sv
